### rtl/core/owb_pkg.sv
// Shared types, constants and helpers for the one-wire bus master.
`timescale 1ns / 1ps
`default_nettype none

package owb_pkg;

   localparam int unsigned TimeWidth  = 10;
   localparam int unsigned NumRegs    = 8;
   localparam int unsigned IndexWidth = 3;

   // Fixed durations of the write-zero release and the read low phase.
   localparam logic [TimeWidth-1:0] Wr0ReleaseTime = 10'd2;
   localparam logic [TimeWidth-1:0] RdLowTime      = 10'd1;
   localparam logic [3:0]           BitsPerByte    = 4'd8;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_RST_LOW = 4'd1,
      PH_RST_WT  = 4'd2,
      PH_RST_TL  = 4'd3,
      PH_WR_LOW  = 4'd4,
      PH_WR_REL  = 4'd5,
      PH_RD_LOW  = 4'd6,
      PH_RD_WT   = 4'd7,
      PH_RD_TL   = 4'd8
   } phase_type;

   typedef enum logic [IndexWidth-1:0] {
      REG_RESET_LOW   = 3'd0,
      REG_PRES_WAIT   = 3'd1,
      REG_PRES_TAIL   = 3'd2,
      REG_WR1_LOW     = 3'd3,
      REG_WR1_RELEASE = 3'd4,
      REG_WR0_LOW     = 3'd5,
      REG_RD_SAMPLE   = 3'd6,
      REG_RD_TAIL     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0] reset_low_time;
      logic [TimeWidth-1:0] presence_wait_time;
      logic [TimeWidth-1:0] presence_tail_time;
      logic [TimeWidth-1:0] write_one_low_time;
      logic [TimeWidth-1:0] write_one_release_time;
      logic [TimeWidth-1:0] write_zero_low_time;
      logic [TimeWidth-1:0] read_sample_delay;
      logic [TimeWidth-1:0] read_tail_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] write_byte;
      logic       line_level;
   } tick_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_byte;
   } result_type;

   // A programmed duration of zero still lasts one tick.
   function automatic logic [TimeWidth-1:0] phase_len(input logic [TimeWidth-1:0] dur);
      phase_len = (dur == '0) ? {{(TimeWidth-1){1'b0}}, 1'b1} : dur;
   endfunction

endpackage

`default_nettype wire

### rtl/core/owb_csr.sv
// Timing register file of the one-wire bus master.
`timescale 1ns / 1ps
`default_nettype none

module owb_csr
   import owb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [IndexWidth-1:0] wr_index,
   input  wire logic [TimeWidth-1:0]  wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_RESET_LOW:   cfg_in.reset_low_time         = wr_data;
            REG_PRES_WAIT:   cfg_in.presence_wait_time     = wr_data;
            REG_PRES_TAIL:   cfg_in.presence_tail_time     = wr_data;
            REG_WR1_LOW:     cfg_in.write_one_low_time     = wr_data;
            REG_WR1_RELEASE: cfg_in.write_one_release_time = wr_data;
            REG_WR0_LOW:     cfg_in.write_zero_low_time    = wr_data;
            REG_RD_SAMPLE:   cfg_in.read_sample_delay      = wr_data;
            REG_RD_TAIL:     cfg_in.read_tail_time         = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time         <= 10'd480;
         cfg_ff.presence_wait_time     <= 10'd60;
         cfg_ff.presence_tail_time     <= 10'd100;
         cfg_ff.write_one_low_time     <= 10'd5;
         cfg_ff.write_one_release_time <= 10'd60;
         cfg_ff.write_zero_low_time    <= 10'd70;
         cfg_ff.read_sample_delay      <= 10'd5;
         cfg_ff.read_tail_time         <= 10'd55;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/owb_engine.sv
// Phase sequencer of the one-wire bus master: one tick of bus timing per step.
`timescale 1ns / 1ps
`default_nettype none

module owb_engine
   import owb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire tick_type tick,
   input  wire cfg_type  cfg,
   output result_type    result
);

   phase_type            phase_ff,    phase_in;
   logic [TimeWidth-1:0] time_ff,     time_in;
   logic [3:0]           bits_ff,     bits_in;
   logic [7:0]           shift_ff,    shift_in;
   logic                 presence_ff, presence_in;
   logic [7:0]           rd_ff,       rd_in;
   logic                 done;

   always_comb begin
      logic [TimeWidth-1:0] tl_dec;
      logic [3:0]           bits_dec;
      logic [7:0]           shift_nx;

      phase_in    = phase_ff;
      time_in     = time_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      rd_in       = rd_ff;
      done        = 1'b0;
      tl_dec      = (time_ff != '0) ? time_ff - 1'b1 : time_ff;
      bits_dec    = bits_ff - 1'b1;
      shift_nx    = {1'b0, shift_ff[7:1]};

      if (phase_ff != PH_IDLE) begin
         time_in = tl_dec;
         if (tl_dec == '0) begin
            case (phase_ff)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WT;
                  time_in  = phase_len(cfg.presence_wait_time);
               end
               PH_RST_WT: begin
                  if (!tick.line_level) begin
                     presence_in = 1'b1;
                     phase_in    = PH_RST_TL;
                     time_in     = phase_len(cfg.presence_tail_time);
                  end else begin
                     presence_in = 1'b0;
                     done        = 1'b1;
                  end
               end
               PH_WR_LOW: begin
                  phase_in = PH_WR_REL;
                  time_in  = shift_ff[0] ? phase_len(cfg.write_one_release_time)
                                         : Wr0ReleaseTime;
               end
               PH_WR_REL: begin
                  shift_in = shift_nx;
                  bits_in  = bits_dec;
                  if (bits_dec == '0) begin
                     done = 1'b1;
                  end else begin
                     phase_in = PH_WR_LOW;
                     time_in  = shift_nx[0] ? phase_len(cfg.write_one_low_time)
                                            : phase_len(cfg.write_zero_low_time);
                  end
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WT;
                  time_in  = phase_len(cfg.read_sample_delay);
               end
               PH_RD_WT: begin
                  shift_in = {tick.line_level, shift_ff[7:1]};
                  phase_in = PH_RD_TL;
                  time_in  = phase_len(cfg.read_tail_time);
               end
               PH_RD_TL: begin
                  bits_in = bits_dec;
                  if (bits_dec == '0) begin
                     rd_in = shift_ff;
                     done  = 1'b1;
                  end else begin
                     phase_in = PH_RD_LOW;
                     time_in  = RdLowTime;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
               time_in  = '0;
            end
         end
      end else begin
         case (cmd_type'(tick.cmd))
            CMD_RESET: begin
               phase_in = PH_RST_LOW;
               time_in  = phase_len(cfg.reset_low_time);
            end
            CMD_WRITE: begin
               shift_in = tick.write_byte;
               bits_in  = BitsPerByte;
               phase_in = PH_WR_LOW;
               time_in  = tick.write_byte[0] ? phase_len(cfg.write_one_low_time)
                                             : phase_len(cfg.write_zero_low_time);
            end
            CMD_READ: begin
               shift_in = '0;
               bits_in  = BitsPerByte;
               phase_in = PH_RD_LOW;
               time_in  = RdLowTime;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      result.drive_low = (phase_in inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW});
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.presence  = presence_in;
      result.read_byte = rd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         time_ff     <= '0;
         bits_ff     <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b0;
         rd_ff       <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         time_ff     <= time_in;
         bits_ff     <= bits_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         rd_ff       <= rd_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/onewire_bus_master_unit.sv
// Top level of the one-wire bus master: tick pipeline, timing registers, sequencer.
//
// Usage: every word on the req_ channel is one microsecond tick. It carries a
// command (none, bus reset, write byte, read byte), the byte to write and the
// bus level sampled during that tick. For each accepted tick exactly one word
// comes out on the rsp_ channel: whether to pull the open-drain line low,
// busy, a one-tick done pulse, the presence flag and the last byte read.
// A command is taken only while the master is idle; otherwise it is ignored.
// From request acceptance to response valid, the word is held in the input
// register, and the sequencer then steps it into the output register.
// Throughput is one tick per clock while the response is not stalled: the
// sequencer advances its phase counter once per word.
// The csr_ channel writes the eight 10-bit timing registers; csr_ready is
// always high and writes are meant to land while the master is idle.
// A synchronous reset empties both pipeline registers, returns the sequencer
// to idle and loads the default timings. When rsp_stall is high the response
// word holds; one further request word is still taken into the input
// register, after which req_stall rises until the response drains.
`timescale 1ns / 1ps
`default_nettype none

module onewire_bus_master_unit
   import owb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [7:0]            req_write_byte,
   input  wire logic                  req_line_level,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_drive_low,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic                       rsp_presence,
   output logic [7:0]                 rsp_read_byte,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [IndexWidth-1:0] csr_index,
   input  wire logic [TimeWidth-1:0]  csr_data
);

   cfg_type    cfg;
   tick_type   tick_ff;
   logic       in_vld_ff,  in_vld_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   result_type step_result;
   logic       out_free;
   logic       step_fire;
   logic       req_take;

   assign csr_ready = 1'b1;

   owb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // The output register frees up when it is empty or being taken this cycle.
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign step_fire = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   owb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step_fire),
      .tick   (tick_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (step_fire) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff && rsp_stall;
      if (step_fire) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff.cmd        <= req_cmd;
         tick_ff.write_byte <= req_write_byte;
         tick_ff.line_level <= req_line_level;
      end
      if (step_fire) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_drive_low = out_ff.drive_low;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_presence  = out_ff.presence;
   assign rsp_read_byte = out_ff.read_byte;

`ifndef SYNTHESIS
   // A sequence that just finished cannot still be busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // The line is only pulled low while a sequence is in progress.
   a_drive_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("line driven low while idle");

   // A held input word implies the response register is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled without a blocked response");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

### tb/sv/onewire_bus_master_unit_tb.sv
// Self-checking testbench for the one-wire bus master: directed table, then random phases.
`timescale 1ns / 1ps

module onewire_bus_master_unit_tb;
   import owb_pkg::*;

   // Ways the timing registers are loaded at the start of a phase.
   typedef enum int {
      TIMING_DIRECTED,
      TIMING_SMALL,
      TIMING_ZERO,
      TIMING_DEFAULT
   } timing_kind_type;

   // Idle and stall patterns of the two handshakes.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One row of the directed table. A row is sent "repeats" times in a row.
   // Where "typed" is set, the expected word is the one written in the row;
   // otherwise the bus model below supplies it.
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       level;
      logic [5:0] repeats;
      logic       typed;
      result_type want;
   } stim_row_type;

   localparam result_type Quiet = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

   // The short timings used by the directed part are 2,1,0,1,1,0,1,0, so a
   // bus reset is two ticks low, one tick of wait, and a presence tail that a
   // zero value stretches to one tick.
   localparam int NumRows = 22;
   localparam stim_row_type DirectedRows [NumRows] = '{
      // Idle after reset: everything reads back as zero.
      '{CMD_NONE,  8'h00, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      // Bus reset where a device answers with a presence pulse.
      '{CMD_RESET, 8'h00, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00}},
      // A command in the tick that completes a sequence is dropped.
      '{CMD_READ,  8'h00, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00}},
      // Bus reset with nobody on the line: presence is cleared at the sample.
      '{CMD_RESET, 8'h00, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
      '{CMD_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      // Write of all ones, then of all zeros with reads offered while busy.
      '{CMD_WRITE, 8'hFF, 1'b0, 6'd1,  1'b0, Quiet},
      '{CMD_NONE,  8'h00, 1'b1, 6'd20, 1'b0, Quiet},
      '{CMD_WRITE, 8'h00, 1'b1, 6'd1,  1'b0, Quiet},
      '{CMD_READ,  8'h00, 1'b1, 6'd23, 1'b0, Quiet},
      '{CMD_NONE,  8'h00, 1'b1, 6'd2,  1'b0, Quiet},
      // Reads of a line that stays high, then of one that stays low.
      '{CMD_READ,  8'h00, 1'b1, 6'd1,  1'b0, Quiet},
      '{CMD_NONE,  8'h00, 1'b1, 6'd26, 1'b0, Quiet},
      '{CMD_READ,  8'h00, 1'b0, 6'd1,  1'b0, Quiet},
      '{CMD_NONE,  8'h00, 1'b0, 6'd26, 1'b0, Quiet},
      // Write of a byte that mixes one and zero slots.
      '{CMD_WRITE, 8'hA5, 1'b0, 6'd1,  1'b0, Quiet},
      '{CMD_NONE,  8'h00, 1'b0, 6'd24, 1'b0, Quiet}
   };

   // Clock, reset and the ports of the block; the driven inputs are known from time zero.
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cmd        = CMD_NONE;
   logic [7:0]            req_write_byte = 8'h00;
   logic                  req_line_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_drive_low;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_presence;
   logic [7:0]            rsp_read_byte;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [IndexWidth-1:0] csr_index      = REG_RESET_LOW;
   logic [TimeWidth-1:0]  csr_data       = '0;

   // Handshake pressure knobs. The stimulus process owns the percentages and
   // the hold request; the stall process owns the hold counter.
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_start    = 1'b0;
   int   hold_left     = 0;

   int   errors = 0;

   // Expected response words, oldest first.
   result_type expected_status [$];

   // Bus model: a copy of the timing registers and of the sequencer state.
   logic [TimeWidth-1:0] timing [NumRegs];
   phase_type            bus_phase  = PH_IDLE;
   logic [TimeWidth-1:0] ticks_left = '0;
   logic [3:0]           bits_left  = '0;
   logic [7:0]           shift_reg  = '0;
   logic                 pres_flag  = 1'b0;
   logic [7:0]           last_read  = '0;

   onewire_bus_master_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_write_byte (req_write_byte),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_presence   (rsp_presence),
      .rsp_read_byte  (rsp_read_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 2 ns clock, high then low.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bus model
   // ---------------------------------------------------------------------

   // Enter a phase; a programmed length of zero still lasts one tick.
   function automatic void enter_phase(input phase_type next, input logic [9:0] span);
      bus_phase  = next;
      ticks_left = (span == '0) ? 10'd1 : span;
   endfunction

   // Each write slot's low time depends on the bit now at the bottom.
   function automatic void start_write_slot();
      enter_phase(PH_WR_LOW, shift_reg[0] ? timing[REG_WR1_LOW] : timing[REG_WR0_LOW]);
   endfunction

   // Called when the current phase has run out. Moves to the next phase and
   // returns 1 when the whole sequence is complete.
   function automatic bit phase_expired(input logic level);
      case (bus_phase)
         PH_RST_LOW: enter_phase(PH_RST_WT, timing[REG_PRES_WAIT]);
         PH_RST_WT: begin
            // A device pulling the line low answers the reset and earns the tail.
            if (!level) begin
               pres_flag = 1'b1;
               enter_phase(PH_RST_TL, timing[REG_PRES_TAIL]);
            end else begin
               pres_flag = 1'b0;
               return 1'b1;
            end
         end
         PH_WR_LOW: begin
            enter_phase(PH_WR_REL,
                        shift_reg[0] ? timing[REG_WR1_RELEASE] : Wr0ReleaseTime);
         end
         PH_WR_REL: begin
            shift_reg = shift_reg >> 1;
            bits_left = bits_left - 4'd1;
            if (bits_left == '0) return 1'b1;
            start_write_slot();
         end
         PH_RD_LOW: enter_phase(PH_RD_WT, timing[REG_RD_SAMPLE]);
         PH_RD_WT: begin
            // Bits arrive LSB first, so each new one enters at the top.
            shift_reg = {level, shift_reg[7:1]};
            enter_phase(PH_RD_TL, timing[REG_RD_TAIL]);
         end
         PH_RD_TL: begin
            bits_left = bits_left - 4'd1;
            if (bits_left == '0) begin
               last_read = shift_reg;
               return 1'b1;
            end
            enter_phase(PH_RD_LOW, RdLowTime);
         end
         default: return 1'b1;
      endcase
      return 1'b0;
   endfunction

   // Advance the bus model by one microsecond tick and return the status word.
   function automatic result_type master_tick(input cmd_type cmd, input logic [7:0] data,
                                              input logic level);
      result_type word;
      logic       done;
      done = 1'b0;
      if (bus_phase != PH_IDLE) begin
         // Busy: the command is ignored, only time moves on.
         if (ticks_left != '0) ticks_left = ticks_left - 10'd1;
         if (ticks_left == '0 && phase_expired(level)) begin
            bus_phase  = PH_IDLE;
            ticks_left = '0;
            done       = 1'b1;
         end
      end else begin
         case (cmd)
            CMD_RESET: enter_phase(PH_RST_LOW, timing[REG_RESET_LOW]);
            CMD_WRITE: begin
               shift_reg = data;
               bits_left = BitsPerByte;
               start_write_slot();
            end
            CMD_READ: begin
               shift_reg = '0;
               bits_left = BitsPerByte;
               enter_phase(PH_RD_LOW, RdLowTime);
            end
            default: ;
         endcase
      end
      word.drive_low = bus_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
      word.busy_res  = bus_phase != PH_IDLE;
      word.done_res  = done;
      word.presence  = pres_flag;
      word.read_byte = last_read;
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // The receiver stalls at random, except during a long hold, which keeps
   // the response stalled for a fixed stretch so that the pipeline backs up
   // all the way to the request side.
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= 80;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Every word taken off the response channel is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("word with nothing pending",
                            int'({rsp_drive_low, rsp_busy_res, rsp_done_res, rsp_presence,
                                  rsp_read_byte}), 0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_drive_low !== want.drive_low)
               report_mismatch("drive_low", int'(rsp_drive_low), int'(want.drive_low));
            if (rsp_busy_res !== want.busy_res)
               report_mismatch("busy_res", int'(rsp_busy_res), int'(want.busy_res));
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", int'(rsp_done_res), int'(want.done_res));
            if (rsp_presence !== want.presence)
               report_mismatch("presence", int'(rsp_presence), int'(want.presence));
            if (rsp_read_byte !== want.read_byte)
               report_mismatch("read_byte", int'(rsp_read_byte), int'(want.read_byte));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one tick word, after an optional random gap, and wait until the
   // block takes it. On acceptance the bus model steps and the expected
   // status word is queued: the typed one where the caller gives it.
   task automatic send_tick(input tick_type tick, input bit typed, input result_type want);
      int         gap;
      result_type predicted;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= tick.cmd;
      req_write_byte <= tick.write_byte;
      req_line_level <= tick.line_level;
      do @(posedge clock); while (req_stall);
      predicted = master_tick(cmd_type'(tick.cmd), tick.write_byte, tick.line_level);
      expected_status.push_back(typed ? want : predicted);
   endtask

   // Mostly well-formed traffic: an idle master usually gets a real command,
   // a busy one mostly gets empty ticks with the odd ignored command as noise.
   // The line level is random, so presence and read bits go both ways.
   function automatic tick_type random_tick();
      tick_type tick;
      tick.write_byte = 8'($urandom_range(255));
      tick.line_level = 1'($urandom_range(1));
      if (bus_phase == PH_IDLE)
         tick.cmd = ($urandom_range(99) < 85) ? 2'($urandom_range(3, 1))
                                               : 2'($urandom_range(3));
      else
         tick.cmd = ($urandom_range(99) < 20) ? 2'($urandom_range(3)) : CMD_NONE;
      return tick;
   endfunction

   // Keep ticking until the sequence in flight has finished.
   task automatic finish_sequence();
      while (bus_phase != PH_IDLE) send_tick(random_tick(), 1'b0, Quiet);
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) send_tick(random_tick(), 1'b0, Quiet);
      finish_sequence();
   endtask

   // Stop offering words and wait until every expected word has come back and
   // the two pipeline registers have emptied.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 9 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 9 : 0;
   endtask

   // Load all eight timing registers, one write per register, while the
   // master is idle. The model copy follows each accepted write.
   task automatic program_timing(input timing_kind_type kind);
      logic [TimeWidth-1:0] vals [NumRegs];
      for (int i = 0; i < NumRegs; i++) begin
         case (kind)
            TIMING_ZERO: vals[i] = '0;
            default:     vals[i] = TimeWidth'($urandom_range(6));
         endcase
      end
      if (kind == TIMING_DIRECTED) begin
         vals[REG_RESET_LOW]   = 10'd2;
         vals[REG_PRES_WAIT]   = 10'd1;
         vals[REG_PRES_TAIL]   = 10'd0;
         vals[REG_WR1_LOW]     = 10'd1;
         vals[REG_WR1_RELEASE] = 10'd1;
         vals[REG_WR0_LOW]     = 10'd0;
         vals[REG_RD_SAMPLE]   = 10'd1;
         vals[REG_RD_TAIL]     = 10'd0;
      end else if (kind == TIMING_DEFAULT) begin
         vals[REG_RESET_LOW]   = 10'd480;
         vals[REG_PRES_WAIT]   = 10'd60;
         vals[REG_PRES_TAIL]   = 10'd100;
         vals[REG_WR1_LOW]     = 10'd5;
         vals[REG_WR1_RELEASE] = 10'd60;
         vals[REG_WR0_LOW]     = 10'd70;
         vals[REG_RD_SAMPLE]   = 10'd5;
         vals[REG_RD_TAIL]     = 10'd55;
      end
      for (int i = 0; i < NumRegs; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         timing[i] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   // One random phase: idle the block, load timings, set the idling pattern,
   // run the requested number of ticks and let the last sequence finish.
   task automatic run_phase(input timing_kind_type kind, input idle_mode_type mode,
                            input int count);
      wait_drained();
      program_timing(kind);
      set_idling(mode);
      run_random(count);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      tick_type tick;

      // The model starts from the reset timings of the block.
      timing[REG_RESET_LOW]   = 10'd480;
      timing[REG_PRES_WAIT]   = 10'd60;
      timing[REG_PRES_TAIL]   = 10'd100;
      timing[REG_WR1_LOW]     = 10'd5;
      timing[REG_WR1_RELEASE] = 10'd60;
      timing[REG_WR0_LOW]     = 10'd70;
      timing[REG_RD_SAMPLE]   = 10'd5;
      timing[REG_RD_TAIL]     = 10'd55;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with short timings and no idling, so that each row of
      // the table lines up with one tick of the sequence it exercises.
      set_idling(IDLE_NONE);
      program_timing(TIMING_DIRECTED);
      for (int r = 0; r < NumRows; r++) begin
         tick.cmd        = DirectedRows[r].cmd;
         tick.write_byte = DirectedRows[r].data;
         tick.line_level = DirectedRows[r].level;
         for (int k = 0; k < DirectedRows[r].repeats; k++)
            send_tick(tick, DirectedRows[r].typed, DirectedRows[r].want);
      end
      finish_sequence();

      // Random part. Most phases use short timings so that many sequences
      // complete; the default timings run only a handful of ticks, since a
      // single sequence there already lasts several hundred ticks.
      run_phase(TIMING_SMALL, IDLE_NONE,     90);
      run_phase(TIMING_SMALL, IDLE_SENDER,   90);
      run_phase(TIMING_SMALL, IDLE_RECEIVER, 90);
      run_phase(TIMING_SMALL, IDLE_BOTH,     90);

      // All registers at zero, which the block stretches to one tick. The
      // receiver holds off for a long stretch while words keep coming, so
      // the block fills up and pushes back on the request side.
      wait_drained();
      program_timing(TIMING_ZERO);
      set_idling(IDLE_NONE);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_random(120);

      run_phase(TIMING_DEFAULT, IDLE_BOTH,     20);
      run_phase(TIMING_SMALL,   IDLE_RECEIVER, 90);

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Safety net: far beyond the slowest correct run, which is dominated by
   // the phases with the longest timings.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
